[src/wavhp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser package
// Shared types, header constants and the sample conversion function.
// ----------------------------------------------------------------------------
package wavhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] FMT_SIZE = 32'h0000_0010;
  localparam logic [15:0] FMT_PCM  = 16'h0001;
  localparam logic [15:0] MONO     = 16'h0001;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [15:0] WIDTH_8  = 16'd8;
  localparam logic [15:0] WIDTH_16 = 16'd16;

  localparam logic [5:0] POS_RIFF  = 6'd3;
  localparam logic [5:0] POS_WAVE  = 6'd11;
  localparam logic [5:0] POS_FMT   = 6'd15;
  localparam logic [5:0] POS_FSIZE = 6'd19;
  localparam logic [5:0] POS_PCM   = 6'd21;
  localparam logic [5:0] POS_CHAN  = 6'd23;
  localparam logic [5:0] POS_RATE  = 6'd27;
  localparam logic [5:0] POS_BITS  = 6'd35;
  localparam logic [5:0] POS_DATA  = 6'd39;
  localparam logic [5:0] POS_DSIZE = 6'd43;

  // Rounded-up 2^24 / 257; exact floor division for every 16-bit input.
  localparam logic [31:0] DIV257_RECIP = 32'h0000_FF01;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_IDLE   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_TAG      = 3'd0,
    ERR_FORMAT   = 3'd1,
    ERR_CHANNELS = 3'd2,
    ERR_WIDTH    = 3'd3,
    ERR_TRUNC    = 3'd4,
    ERR_NONE     = 3'd5
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_beat_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  sample_value;
    logic [31:0] rate_hz;
    err_t        error_code;
    logic        final_sample;
  } result_t;

  function automatic logic [7:0] div257(input logic [15:0] v);
    logic [31:0] p;
    p = 32'(v) * DIV257_RECIP;
    return p[31:24];
  endfunction

endpackage
`default_nettype wire

[src/wavhp_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Input register
// Holds one incoming beat until the parser core consumes it.
// ----------------------------------------------------------------------------
module wavhp_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire wavhp_pkg::in_beat_t in_beat,
  input  wire logic              take,
  output logic                   held_valid,
  output wavhp_pkg::in_beat_t    held_beat
);
  import wavhp_pkg::*;

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_beat <= in_beat;
    end
  end

endmodule
`default_nettype wire

[src/wavhp_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Parser core
// Header checks, data phase state and sample conversion, one byte per beat.
// ----------------------------------------------------------------------------
module wavhp_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire wavhp_pkg::in_beat_t beat,
  output logic                     res_valid,
  output wavhp_pkg::result_t       res
);
  import wavhp_pkg::*;

  phase_t      phase, phase_next;
  logic [5:0]  header_position, header_position_next;
  logic [31:0] field_assembly, field_assembly_next;
  logic [31:0] rate_store, rate_store_next;
  logic        width8, width8_next;
  logic        width16, width16_next;
  logic [31:0] samples_left, samples_left_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic        byte_phase, byte_phase_next;

  logic [31:0] fa_shift;
  logic [15:0] hi16;
  logic        hdr_fail;
  err_t        hdr_code;
  logic        hdr_done;
  logic [31:0] hdr_count;
  logic        produced;
  logic [7:0]  value;
  logic [31:0] sl_dec;
  logic [31:0] sl_after;
  logic        eof;

  assign eof      = beat.end_of_file;
  assign fa_shift = {beat.data_byte, field_assembly[31:8]};
  assign hi16     = fa_shift[31:16];
  assign sl_dec   = samples_left - 32'd1;
  assign sl_after = produced ? sl_dec : samples_left;

  always_comb begin
    hdr_fail             = 1'b0;
    hdr_code             = ERR_TAG;
    hdr_done             = 1'b0;
    hdr_count            = '0;
    produced             = 1'b0;
    value                = '0;
    header_position_next = header_position;
    field_assembly_next  = field_assembly;
    rate_store_next      = rate_store;
    width8_next          = width8;
    width16_next         = width16;
    samples_left_next    = samples_left;
    low_byte_hold_next   = low_byte_hold;
    byte_phase_next      = byte_phase;
    case (phase)
      PH_HEADER: begin
        field_assembly_next  = fa_shift;
        header_position_next = header_position + 6'd1;
        case (header_position)
          POS_RIFF:  hdr_fail = (fa_shift != TAG_RIFF);
          POS_WAVE:  hdr_fail = (fa_shift != TAG_WAVE);
          POS_FMT:   hdr_fail = (fa_shift != TAG_FMT);
          POS_FSIZE: hdr_fail = (fa_shift != FMT_SIZE);
          POS_PCM: begin
            hdr_fail = (hi16 != FMT_PCM);
            hdr_code = ERR_FORMAT;
          end
          POS_CHAN: begin
            hdr_fail = (hi16 != MONO);
            hdr_code = ERR_CHANNELS;
          end
          POS_RATE:  rate_store_next = fa_shift;
          POS_BITS: begin
            width8_next  = (hi16 == WIDTH_8);
            width16_next = (hi16 == WIDTH_16);
          end
          POS_DATA:  hdr_fail = (fa_shift != TAG_DATA);
          POS_DSIZE: begin
            if (width8) begin
              hdr_count = fa_shift;
              hdr_done  = 1'b1;
            end else if (width16) begin
              hdr_count = {1'b0, fa_shift[31:1]};
              hdr_done  = 1'b1;
            end else begin
              hdr_fail = 1'b1;
              hdr_code = ERR_WIDTH;
            end
          end
          default: begin
          end
        endcase
        if (hdr_done) begin
          samples_left_next = hdr_count;
          byte_phase_next   = 1'b0;
        end
      end
      PH_DATA: begin
        if (width8) begin
          produced = 1'b1;
          value    = beat.data_byte;
        end else if (!byte_phase) begin
          low_byte_hold_next = beat.data_byte;
          byte_phase_next    = 1'b1;
        end else begin
          produced        = 1'b1;
          value           = div257({~beat.data_byte[7], beat.data_byte[6:0], low_byte_hold});
          byte_phase_next = 1'b0;
        end
        if (produced) begin
          samples_left_next = sl_dec;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    phase_next = phase;
    if (eof) begin
      phase_next = PH_HEADER;
    end else begin
      case (phase)
        PH_HEADER: begin
          if (hdr_fail) begin
            phase_next = PH_IDLE;
          end else if (hdr_done) begin
            phase_next = (hdr_count != 32'd0) ? PH_DATA : PH_IDLE;
          end
        end
        PH_DATA: begin
          if (produced && sl_dec == 32'd0) begin
            phase_next = PH_IDLE;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  always_comb begin
    res_valid        = 1'b0;
    res.kind         = KIND_SAMPLE;
    res.sample_value = '0;
    res.rate_hz      = '0;
    res.error_code   = ERR_NONE;
    res.final_sample = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (hdr_fail) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = hdr_code;
        end else if (hdr_done && !(eof && hdr_count != 32'd0)) begin
          res_valid   = 1'b1;
          res.kind    = KIND_HEADER;
          res.rate_hz = rate_store;
        end else if (eof) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNC;
        end
      end
      PH_DATA: begin
        if (eof && sl_after != 32'd0) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNC;
        end else if (produced) begin
          res_valid        = 1'b1;
          res.sample_value = value;
          res.final_sample = (sl_dec == 32'd0);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_position <= '0;
      field_assembly  <= '0;
      rate_store      <= '0;
      width8          <= 1'b0;
      width16         <= 1'b0;
      samples_left    <= '0;
      low_byte_hold   <= '0;
      byte_phase      <= 1'b0;
    end else if (fire) begin
      if (eof) begin
        phase           <= PH_HEADER;
        header_position <= '0;
        field_assembly  <= '0;
        rate_store      <= '0;
        width8          <= 1'b0;
        width16         <= 1'b0;
        samples_left    <= '0;
        low_byte_hold   <= '0;
        byte_phase      <= 1'b0;
      end else begin
        phase           <= phase_next;
        header_position <= header_position_next;
        field_assembly  <= field_assembly_next;
        rate_store      <= rate_store_next;
        width8          <= width8_next;
        width16         <= width16_next;
        samples_left    <= samples_left_next;
        low_byte_hold   <= low_byte_hold_next;
        byte_phase      <= byte_phase_next;
      end
    end
  end

endmodule
`default_nettype wire

[src/wavhp_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module wavhp_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire logic               res_valid,
  input  wire wavhp_pkg::result_t res,
  output logic                    can_take,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output wavhp_pkg::result_t      out_res
);
  import wavhp_pkg::*;

  assign can_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && fire && res_valid) begin
      out_res <= res;
    end
  end

endmodule
`default_nettype wire

[src/wav_header_parse_and_sample_convert.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser and sample converter
// Checks a 44-byte mono PCM WAV header and converts the data chunk to
// unsigned 8-bit samples.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle and gives at most one result beat
// per byte; an accepted byte passes through one input register and one
// result register, with the header check and the 16-bit to 8-bit
// conversion done in a single pass between them. Throughput stays at one
// byte per cycle as long as the consumer takes results; a stalled result
// register holds the input side after one more byte. No clearing pass
// follows reset.
module wav_header_parse_and_sample_convert (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_file,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       sample_value,
  output logic [31:0]      rate_hz,
  output logic [2:0]       error_code,
  output logic             final_sample
);
  import wavhp_pkg::*;

  in_beat_t in_beat;
  in_beat_t held_beat;
  logic     held_valid;
  logic     can_take;
  logic     fire;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign in_beat.data_byte   = data_byte;
  assign in_beat.end_of_file = end_of_file;
  assign fire                = held_valid && can_take;

  wavhp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .take       (can_take),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  wavhp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .beat      (held_beat),
    .res_valid (res_valid),
    .res       (res)
  );

  wavhp_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind         = out_res.kind;
  assign sample_value = out_res.sample_value;
  assign rate_hz      = out_res.rate_hz;
  assign error_code   = out_res.error_code;
  assign final_sample = out_res.final_sample;

  a_empty_accepts : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input stalled while the result register is empty.");

  a_final_is_sample : assert property (@(posedge clk) disable iff (rst)
    (out_valid && final_sample) |-> (kind == KIND_SAMPLE))
    else $error("Final flag on a beat that is not a sample.");

  a_error_code_match : assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_ERROR) |-> (error_code == ERR_NONE))
    else $error("Error code set on a beat that is not an error.");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    (held_valid && !can_take) |=> held_valid)
    else $error("Held input beat dropped during a stall.");

endmodule
`default_nettype wire
